@@ rtl/core/ddwpm_pkg.sv @@
package ddwpm_pkg;

  localparam int unsigned StageCnt  = 10;
  localparam int unsigned LastStage = StageCnt - 1;

  localparam int unsigned PulseW   = 12;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned SpeedInW = 16;
  localparam int unsigned MaskW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Wheel speed in units of 1/819200 rad/s.
  localparam int unsigned WheelW = 29;
  localparam int unsigned TermW  = 28;

  localparam int unsigned VCoef         = 2500;
  localparam int unsigned WCoef         = 2159;
  localparam int unsigned DeadbandUnits = 163840;
  localparam int unsigned LimitScale    = 800;
  localparam int unsigned KickUs        = 120;
  localparam int unsigned GainDenom     = 26050560;
  localparam int unsigned GainHalf      = GainDenom / 2;

  // The denominator is 2^15 * 795; the odd part is divided by reciprocal.
  localparam int unsigned DenomShift = 15;
  localparam int unsigned DenomOdd   = 795;
  localparam int unsigned RecipShift = 34;
  localparam int unsigned Recip      = 21609898;

  localparam logic [PulseW-1:0] NeutralRst  = 12'd1480;
  localparam logic [PulseW-1:0] FwdTopRst   = 12'd1950;
  localparam logic [PulseW-1:0] RevTopRst   = 12'd1050;
  localparam logic [PulseW-1:0] FloorRst    = 12'd1000;
  localparam logic [PulseW-1:0] CeilingRst  = 12'd2000;
  localparam logic [LimitW-1:0] LimitRst    = 16'd32973;
  localparam logic [MaskW-1:0]  InvertRst   = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    RegNeutral = 3'd0,
    RegFwdTop  = 3'd1,
    RegRevTop  = 3'd2,
    RegFloor   = 3'd3,
    RegCeiling = 3'd4,
    RegLimit   = 3'd5,
    RegInvert  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PulseW-1:0] neutral;
    logic [PulseW-1:0] fwd_top;
    logic [PulseW-1:0] rev_top;
    logic [PulseW-1:0] pulse_floor;
    logic [PulseW-1:0] pulse_ceiling;
    logic [LimitW-1:0] limit;
  } wheel_cfg_t;

  typedef logic [StageCnt-1:0] stage_en_t;

endpackage

@@ rtl/core/diff_drive_wheel_pulse_mapper.sv @@
// Maps a body command (linear speed in signed Q3.12 m/s, turn rate in signed
// Q5.10 rad/s) to left and right servo pulse widths in whole microseconds. One
// request is taken every cycle while the output is not stalled; its result is
// carried through the ten register stages of the exact fixed-point multiply and
// divide chain, and a stalled output fills empty stages before input ready
// drops. Configuration registers must only be written while no request is in
// flight.
module diff_drive_wheel_pulse_mapper import ddwpm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SpeedInW-1:0] linear_speed_i,
  input  logic signed [SpeedInW-1:0] turn_rate_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [PulseW-1:0]          left_pulse_o,
  output logic [PulseW-1:0]          right_pulse_o
);

  wheel_cfg_t       cfg_q;
  logic [MaskW-1:0] invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neutral       <= NeutralRst;
      cfg_q.fwd_top       <= FwdTopRst;
      cfg_q.rev_top       <= RevTopRst;
      cfg_q.pulse_floor   <= FloorRst;
      cfg_q.pulse_ceiling <= CeilingRst;
      cfg_q.limit         <= LimitRst;
      invert_q            <= InvertRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegNeutral: cfg_q.neutral       <= cfg_wdata_i[PulseW-1:0];
        RegFwdTop:  cfg_q.fwd_top       <= cfg_wdata_i[PulseW-1:0];
        RegRevTop:  cfg_q.rev_top       <= cfg_wdata_i[PulseW-1:0];
        RegFloor:   cfg_q.pulse_floor   <= cfg_wdata_i[PulseW-1:0];
        RegCeiling: cfg_q.pulse_ceiling <= cfg_wdata_i[PulseW-1:0];
        RegLimit:   cfg_q.limit         <= cfg_wdata_i[LimitW-1:0];
        RegInvert:  invert_q            <= cfg_wdata_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it loads.
  stage_en_t stage_en;
  stage_en_t vld_q, vld_d, vld_in;

  always_comb begin
    stage_en[LastStage] = out_ready_i || !vld_q[LastStage];
    for (int k = LastStage - 1; k >= 0; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
    vld_in = {vld_q[LastStage-1:0], in_valid_i};
    vld_d  = (stage_en & vld_in) | (~stage_en & vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = vld_q[LastStage];

  // Stage 0: scale both command terms to wheel speed units.
  logic signed [TermW-1:0] pv_q, pw_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      pv_q <= TermW'(linear_speed_i) * TermW'(VCoef);
      pw_q <= TermW'(turn_rate_i) * TermW'(WCoef);
    end
  end

  // Stage 1: wheel speeds with per-wheel inversion.
  logic signed [WheelW-1:0] left_d, right_d, left_q, right_q;

  always_comb begin
    left_d  = WheelW'(pv_q) - WheelW'(pw_q);
    right_d = WheelW'(pv_q) + WheelW'(pw_q);
    if (invert_q[0]) begin
      left_d = -left_d;
    end
    if (invert_q[1]) begin
      right_d = -right_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  ddwpm_wheel u_left (
    .clk_i   (clk_i),
    .en_i    (stage_en),
    .cfg_i   (cfg_q),
    .speed_i (left_q),
    .pulse_o (left_pulse_o)
  );

  ddwpm_wheel u_right (
    .clk_i   (clk_i),
    .en_i    (stage_en),
    .cfg_i   (cfg_q),
    .speed_i (right_q),
    .pulse_o (right_pulse_o)
  );

`ifndef SYNTH
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[LastStage] |-> in_ready_o) else $error("input stalled with empty output");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q)) else $error("input stalled with a bubble in the pipe");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LastStage] && !out_ready_i |=> vld_q[LastStage])
    else $error("result dropped while stalled");

  a_request_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0]) else $error("accepted request lost");
`endif

endmodule

@@ rtl/core/ddwpm_wheel.sv @@
module ddwpm_wheel import ddwpm_pkg::*; (
  input  logic                     clk_i,
  input  stage_en_t                en_i,
  input  wheel_cfg_t               cfg_i,
  input  logic signed [WheelW-1:0] speed_i,
  output logic [PulseW-1:0]        pulse_o
);

  localparam int unsigned MagW  = WheelW - 1;
  localparam int unsigned CapW  = 26;
  localparam int unsigned DmW   = CapW + 1;
  localparam int unsigned SpanW = 14;
  localparam int unsigned ProdW = SpanW + DmW;
  localparam int unsigned NeutW = 37;
  localparam int unsigned NumW  = 42;
  localparam int unsigned XW    = 25;
  localparam int unsigned PW    = 50;
  localparam int unsigned QeW   = PW - RecipShift;
  localparam int unsigned QW    = QeW + 1;
  localparam int unsigned RemW  = 11;
  localparam int unsigned RW    = QW + 1;

  localparam logic signed [WheelW-1:0] DbSpeed  = WheelW'(DeadbandUnits);
  localparam logic signed [DmW-1:0]    DbDm     = DmW'(DeadbandUnits);
  localparam logic signed [SpanW-1:0]  KickSpan = SpanW'(KickUs);
  localparam logic signed [NumW-1:0]   KickTerm = NumW'(KickUs) * NumW'(GainDenom);
  localparam logic [NumW-1:0]          HalfNum  = NumW'(GainHalf);

  // Stage 2: deadband test, direction and magnitude.
  logic            db2_q, fwd2_q;
  logic [MagW-1:0] mag2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      db2_q  <= (speed_i > -DbSpeed) && (speed_i < DbSpeed);
      fwd2_q <= !speed_i[WheelW-1] && (speed_i != '0);
      mag2_q <= speed_i[WheelW-1] ? MagW'(-speed_i) : MagW'(speed_i);
    end
  end

  // Stage 3: speed cap and span from neutral.
  logic [CapW-1:0]         cap_w, capm_w;
  logic signed [SpanW-1:0] span_d;
  logic                    db3_q, fwd3_q;
  logic signed [DmW-1:0]   dm3_q;
  logic signed [SpanW-1:0] span3_q;

  always_comb begin
    cap_w  = CapW'(cfg_i.limit) * CapW'(LimitScale);
    capm_w = (mag2_q > {2'b00, cap_w}) ? cap_w : CapW'(mag2_q);
    if (fwd2_q) begin
      span_d = $signed({2'b00, cfg_i.fwd_top}) - $signed({2'b00, cfg_i.neutral}) - KickSpan;
    end else begin
      span_d = $signed({2'b00, cfg_i.neutral}) - $signed({2'b00, cfg_i.rev_top}) - KickSpan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      db3_q   <= db2_q;
      fwd3_q  <= fwd2_q;
      dm3_q   <= $signed({1'b0, capm_w}) - DbDm;
      span3_q <= span_d;
    end
  end

  // Stage 4: gain product and scaled neutral.
  logic                    db4_q, fwd4_q;
  logic signed [ProdW-1:0] prod4_q;
  logic [NeutW-1:0]        neut4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      db4_q   <= db3_q;
      fwd4_q  <= fwd3_q;
      prod4_q <= ProdW'(span3_q) * ProdW'(dm3_q);
      neut4_q <= NeutW'(cfg_i.neutral) * NeutW'(GainDenom);
    end
  end

  // Stage 5: numerator of the pulse over the gain denominator.
  logic signed [NumW-1:0] term_w;
  logic                   db5_q;
  logic signed [NumW-1:0] num5_q;

  assign term_w = KickTerm + NumW'(prod4_q);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      db5_q  <= db4_q;
      num5_q <= $signed({5'b00000, neut4_q}) + (fwd4_q ? term_w : -term_w);
    end
  end

  // Stage 6: magnitude plus half, power of two part of the division.
  logic [NumW-1:0] abs_w, sum_w;
  logic            db6_q, neg6_q;
  logic [XW-1:0]   x6_q;

  always_comb begin
    abs_w = num5_q[NumW-1] ? NumW'(-num5_q) : NumW'(num5_q);
    sum_w = abs_w + HalfNum;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      db6_q  <= db5_q;
      neg6_q <= num5_q[NumW-1];
      x6_q   <= XW'(sum_w >> DenomShift);
    end
  end

  // Stage 7: reciprocal product for the odd part of the division.
  logic          db7_q, neg7_q;
  logic [XW-1:0] x7_q;
  logic [PW-1:0] p7_q;

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      db7_q  <= db6_q;
      neg7_q <= neg6_q;
      x7_q   <= x6_q;
      p7_q   <= PW'(x6_q) * PW'(Recip);
    end
  end

  // Stage 8: quotient estimate and remainder.
  logic [QeW-1:0]  qe_w;
  logic [XW-1:0]   qm_w;
  logic            db8_q, neg8_q;
  logic [QeW-1:0]  qe8_q;
  logic [RemW-1:0] rem8_q;

  always_comb begin
    qe_w = p7_q[PW-1 -: QeW];
    qm_w = XW'(qe_w) * XW'(DenomOdd);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      db8_q  <= db7_q;
      neg8_q <= neg7_q;
      qe8_q  <= qe_w;
      rem8_q <= RemW'(x7_q - qm_w);
    end
  end

  // Stage 9: quotient correction, sign, deadband select and clamp.
  logic [QW-1:0]        q_w;
  logic signed [RW-1:0] r_w, sel_w, clamp_w;
  logic [PulseW-1:0]    pulse9_q;

  always_comb begin
    q_w = (rem8_q >= RemW'(DenomOdd)) ? QW'(qe8_q) + QW'(1) : QW'(qe8_q);
    r_w = neg8_q ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});
    sel_w = db8_q ? $signed(RW'(cfg_i.neutral)) : r_w;
    clamp_w = sel_w;
    if (clamp_w < $signed(RW'(cfg_i.pulse_floor))) begin
      clamp_w = $signed(RW'(cfg_i.pulse_floor));
    end
    if (clamp_w > $signed(RW'(cfg_i.pulse_ceiling))) begin
      clamp_w = $signed(RW'(cfg_i.pulse_ceiling));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      pulse9_q <= PulseW'(clamp_w);
    end
  end

  assign pulse_o = pulse9_q;

endmodule

@@ dv/diff_drive_wheel_pulse_mapper_tb.sv @@
module diff_drive_wheel_pulse_mapper_tb;
  import ddwpm_pkg::*;

  localparam longint DeadUnits = DeadbandUnits;
  localparam longint Denom     = GainDenom;
  localparam longint HalfDenom = GainHalf;
  localparam longint Kick      = KickUs;
  localparam longint CapScale  = LimitScale;
  localparam longint SpeedCoef = VCoef;
  localparam longint TurnCoef  = WCoef;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  localparam int unsigned PhaseCnt    = 9;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = StageCnt + 4;

  typedef struct {
    logic signed [SpeedInW-1:0] lin;
    logic signed [SpeedInW-1:0] turn;
  } body_cmd_t;

  typedef struct {
    logic [PulseW-1:0] left;
    logic [PulseW-1:0] right;
  } pulse_pair_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]         cfg_idx_i   = '0;
  logic [CfgDataW-1:0]        cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic signed [SpeedInW-1:0] linear_speed_i = '0;
  logic signed [SpeedInW-1:0] turn_rate_i    = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [PulseW-1:0]          left_pulse_o;
  logic [PulseW-1:0]          right_pulse_o;

  logic [PulseW-1:0] m_neutral = NeutralRst;
  logic [PulseW-1:0] m_fwd_top = FwdTopRst;
  logic [PulseW-1:0] m_rev_top = RevTopRst;
  logic [PulseW-1:0] m_floor   = FloorRst;
  logic [PulseW-1:0] m_ceiling = CeilingRst;
  logic [LimitW-1:0] m_limit   = LimitRst;
  logic [MaskW-1:0]  m_invert  = InvertRst;

  body_cmd_t   cmd_q[$];
  pulse_pair_t pulse_q[$];
  body_cmd_t   next_cmd;
  pulse_pair_t exp_pair;

  bit          pace_on   = 1'b1;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned stall_cnt = 0;
  int unsigned err_cnt   = 0;

  diff_drive_wheel_pulse_mapper dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .linear_speed_i (linear_speed_i),
    .turn_rate_i    (turn_rate_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_pulse_o   (left_pulse_o),
    .right_pulse_o  (right_pulse_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [PulseW-1:0] wheel_speed_to_pulse(input longint speed);
    longint neutral, mag, cap, span, term, num, r;
    bit     fwd;
    neutral = longint'(m_neutral);
    if (speed > -DeadUnits && speed < DeadUnits) begin
      r = neutral;
    end else begin
      fwd = speed > 0;
      mag = fwd ? speed : -speed;
      cap = longint'(m_limit) * CapScale;
      if (mag > cap) mag = cap;
      span = fwd ? longint'(m_fwd_top) - neutral : neutral - longint'(m_rev_top);
      term = Kick * Denom + (span - Kick) * (mag - DeadUnits);
      num  = neutral * Denom + (fwd ? term : -term);
      if (num >= 0) r = (num + HalfDenom) / Denom;
      else r = -((-num + HalfDenom) / Denom);
    end
    if (r < longint'(m_floor)) r = longint'(m_floor);
    if (r > longint'(m_ceiling)) r = longint'(m_ceiling);
    return r[PulseW-1:0];
  endfunction

  function automatic pulse_pair_t pulses_for_cmd(input body_cmd_t cmd);
    longint      v, w, left, right;
    pulse_pair_t p;
    v = longint'(cmd.lin);
    w = longint'(cmd.turn);
    left  = SpeedCoef * v - TurnCoef * w;
    right = SpeedCoef * v + TurnCoef * w;
    if (m_invert[0]) left = -left;
    if (m_invert[1]) right = -right;
    p.left  = wheel_speed_to_pulse(left);
    p.right = wheel_speed_to_pulse(right);
    return p;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!pace_on || roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      linear_speed_i <= '0;
      turn_rate_i    <= '0;
      send_gap       <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        next_cmd.lin  = linear_speed_i;
        next_cmd.turn = turn_rate_i;
        pulse_q.push_back(pulses_for_cmd(next_cmd));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          next_cmd = cmd_q.pop_front();
          linear_speed_i <= next_cmd.lin;
          turn_rate_i    <= next_cmd.turn;
          in_valid_i     <= 1'b1;
          send_gap       <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pulse_q.size() == 0) begin
          $display("%0t: result with no request pending: left %0d right %0d",
                   $time, left_pulse_o, right_pulse_o);
          err_cnt++;
        end else begin
          exp_pair = pulse_q.pop_front();
          if (left_pulse_o !== exp_pair.left) begin
            $display("%0t: left pulse mismatch: expected %0d, actual %0d",
                     $time, exp_pair.left, left_pulse_o);
            err_cnt++;
          end
          if (right_pulse_o !== exp_pair.right) begin
            $display("%0t: right pulse mismatch: expected %0d, actual %0d",
                     $time, exp_pair.right, right_pulse_o);
            err_cnt++;
          end
        end
      end
      if (stall_cnt != 0) begin
        stall_cnt   <= stall_cnt - 1;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        stall_cnt   <= HoldCycles - 1;
        hold_done   <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        automatic int unsigned g = pick_gap();
        if (g == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          stall_cnt   <= g - 1;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegNeutral: m_neutral = data[PulseW-1:0];
      RegFwdTop:  m_fwd_top = data[PulseW-1:0];
      RegRevTop:  m_rev_top = data[PulseW-1:0];
      RegFloor:   m_floor   = data[PulseW-1:0];
      RegCeiling: m_ceiling = data[PulseW-1:0];
      RegLimit:   m_limit   = data[LimitW-1:0];
      RegInvert:  m_invert  = data[MaskW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input int neutral, input int fwd, input int rev, input int lo,
                         input int hi, input int limit, input int inv);
    write_reg(RegNeutral, CfgDataW'(neutral));
    write_reg(RegFwdTop, CfgDataW'(fwd));
    write_reg(RegRevTop, CfgDataW'(rev));
    write_reg(RegFloor, CfgDataW'(lo));
    write_reg(RegCeiling, CfgDataW'(hi));
    write_reg(RegLimit, CfgDataW'(limit));
    write_reg(RegInvert, CfgDataW'(($urandom() & 32'hFFFC) | inv));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_cmd(input int v, input int w);
    body_cmd_t c;
    c.lin  = SpeedInW'(v);
    c.turn = SpeedInW'(w);
    cmd_q.push_back(c);
  endtask

  // Picks a command whose left wheel speed, before inversion, equals target.
  task automatic push_left_speed(input int target);
    int k;
    for (k = 0; k < 2500; k++) begin
      if ((target + 2159 * k) % 2500 == 0) begin
        push_cmd((target + 2159 * k) / 2500, k);
        return;
      end
    end
  endtask

  task automatic push_random(input int unsigned n);
    int unsigned roll;
    int          v, w;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        v = $urandom();
        w = $urandom();
      end else if (roll < 70) begin
        v = int'($urandom_range(0, 256)) - 128;
        w = int'($urandom_range(0, 256)) - 128;
      end else if (roll < 90) begin
        v = int'($urandom_range(0, 8192)) - 4096;
        w = int'($urandom_range(0, 8192)) - 4096;
      end else begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          default: v = $urandom();
        endcase
        case ($urandom_range(0, 3))
          0: w = 32767;
          1: w = -32768;
          2: w = 0;
          default: w = $urandom();
        endcase
      end
      push_cmd(v, w);
    end
  endtask

  // Checks at the falling edge, when every update of the rising edge has settled.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid_i || pulse_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < PhaseCnt; p++) begin
      pace_on <= (p % 3) != 1;
      case (p)
        0: ;
        1: set_all(500, 2500, 500, 500, 2500, 65535, 0);
        2: set_all(2500, 500, 2500, 2500, 500, 0, 3);
        3: begin
          write_reg(RegUnused, CfgDataW'($urandom()));
          set_all(1500, 2000, 1000, 500, 2500, 150, 2);
        end
        default: set_all($urandom_range(500, 2500), $urandom_range(500, 2500),
                         $urandom_range(500, 2500), $urandom_range(500, 1500),
                         $urandom_range(1500, 2500), $urandom_range(0, 65535),
                         $urandom_range(0, 3));
      endcase
      if (p == 0) begin
        push_cmd(0, 0);
        push_cmd(32767, 0);
        push_cmd(-32768, 0);
        push_cmd(0, 32767);
        push_cmd(0, -32768);
        push_cmd(32767, 32767);
        push_cmd(-32768, -32768);
        push_cmd(32767, -32768);
        push_cmd(-32768, 32767);
        push_cmd(1, 0);
        push_cmd(-1, -1);
        push_left_speed(DeadbandUnits);
        push_left_speed(-DeadbandUnits);
        push_left_speed(DeadbandUnits - 1);
        push_left_speed(-DeadbandUnits + 1);
        push_left_speed(DeadbandUnits + 1);
        push_left_speed(-DeadbandUnits - 1);
        push_left_speed(LimitRst * LimitScale);
        push_left_speed(-(LimitRst * LimitScale));
      end
      if (p == 4) begin
        push_random(PhaseItems / 2);
        wait_idle();
        push_random(PhaseItems / 2);
      end else begin
        push_random(PhaseItems);
      end
      if (p == 2) hold_req <= 1'b1;
      wait_idle();
    end
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
